@@ sv/gmg_pkg.sv @@
// gmg_pkg: shared constants, command/status types and elaboration-time
// table functions for the GPS movement gate.
// No dependencies.
package gmg_pkg;

   localparam int CORDIC_STEPS_DEFAULT = 24;
   localparam int TRIG_FRACTION_BITS_DEFAULT = 30;

   localparam int LAT_W = 28;
   localparam int LON_W = 29;
   localparam int DIST_W = 24;
   localparam int THR_W = 24;
   localparam int ANG_W = 30;        // wrapped angle before reduction
   localparam int RED_W = 29;        // reduced angle, within a quarter turn
   localparam int COORD_FRAC = 8;
   localparam int COORD_W = 34;
   localparam int DABS_W = 34;
   localparam int CNT_W = 5;         // step counter, 32 steps max

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(50);
   localparam logic signed [24:0] EARTH_RADIUS_M = 25'sd6371000;
   localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(180000000);
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(90000000);
   localparam logic signed [ANG_W-1:0] FULL_TURN = ANG_W'(360000000);

   // datapath operations
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_LOAD   = 4'd1;
   localparam logic [3:0] OP_RED    = 4'd2;
   localparam logic [3:0] OP_MUL    = 4'd3;
   localparam logic [3:0] OP_ZINIT  = 4'd4;
   localparam logic [3:0] OP_ITER   = 4'd5;
   localparam logic [3:0] OP_SAVE   = 4'd6;
   localparam logic [3:0] OP_TMUL   = 4'd7;
   localparam logic [3:0] OP_RMUL   = 4'd8;
   localparam logic [3:0] OP_DABS   = 4'd9;
   localparam logic [3:0] OP_DSQ    = 4'd10;
   localparam logic [3:0] OP_SQINIT = 4'd11;
   localparam logic [3:0] OP_SQSTEP = 4'd12;
   localparam logic [3:0] OP_FIN    = 4'd13;

   typedef struct packed {
      logic [3:0]       op;
      logic [1:0]       ang;    // 0 new lat, 1 new lon, 2 stored lat, 3 stored lon
      logic [2:0]       pt;     // coordinate / axis select
      logic [CNT_W-1:0] step;   // CORDIC or root step
   } cmd_type;

   typedef struct packed {
      logic out_full;           // result register holds an untaken transfer
   } status_type;

   // restoring shift-subtract quotient, elaboration use only
   function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic longint unsigned isqrt64(longint unsigned v);
      longint unsigned rem;
      longint unsigned res;
      longint unsigned b;
      rem = v;
      res = 0;
      b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= res + b) begin
            rem = rem - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // atan(1/d) in Q61 by series, each term floored
   function automatic longint atan_inv(longint unsigned d);
      longint unsigned p;
      longint unsigned k;
      longint sum;
      longint term;
      p = udiv64(64'd1 << 61, d);
      k = 0;
      sum = 0;
      while (p != 0) begin
         term = longint'(udiv64(p, 2 * k + 1));
         if (k[0]) sum = sum - term;
         else sum = sum + term;
         p = udiv64(p, d * d);
         k = k + 1;
      end
      return sum;
   endfunction

   function automatic longint quarter_pi();
      return 4 * atan_inv(64'd5) - atan_inv(64'd239);
   endfunction

   function automatic logic [63:0] atan_entry(int i);
      if (i == 0) return 64'(quarter_pi());
      return 64'(atan_inv(64'd1 << i));
   endfunction

   function automatic longint unsigned angle_k();
      return udiv64(64'(4 * quarter_pi()), 64'd180000000);
   endfunction

   function automatic longint unsigned inv_gain(int steps, int f);
      longint unsigned prod;
      prod = 64'd1 << (2 * f);
      for (int i = 0; i < steps && i < 32; i++) prod = prod + (prod >> (2 * i));
      return udiv64(64'd1 << (2 * f), isqrt64(prod));
   endfunction

   // angle scale split in two halves for narrow multiplies
   localparam longint unsigned ANGLE_K = angle_k();
   localparam logic [17:0] ANGLE_K_LO = ANGLE_K[17:0];
   localparam logic [17:0] ANGLE_K_HI = ANGLE_K[35:18];

endpackage

@@ sv/gmg_ctrl.sv @@
// gmg_ctrl: sequencer for the movement gate; issues one datapath command
// per cycle unless held by a full result register. Depends on gmg_pkg.
module gmg_ctrl #(
   parameter int CORDIC_STEPS = gmg_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  gmg_pkg::status_type  status,
   output gmg_pkg::cmd_type     cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RED    = 4'd1;
   localparam logic [3:0] S_MUL    = 4'd2;
   localparam logic [3:0] S_ZINIT  = 4'd3;
   localparam logic [3:0] S_ITER   = 4'd4;
   localparam logic [3:0] S_SAVE   = 4'd5;
   localparam logic [3:0] S_TMUL   = 4'd6;
   localparam logic [3:0] S_RMUL   = 4'd7;
   localparam logic [3:0] S_DABS   = 4'd8;
   localparam logic [3:0] S_DSQ    = 4'd9;
   localparam logic [3:0] S_SQINIT = 4'd10;
   localparam logic [3:0] S_SQSTEP = 4'd11;
   localparam logic [3:0] S_FIN    = 4'd12;

   localparam logic [gmg_pkg::CNT_W-1:0] LAST_ITER = gmg_pkg::CNT_W'(CORDIC_STEPS - 1);
   localparam logic [gmg_pkg::CNT_W-1:0] LAST_ROOT = gmg_pkg::CNT_W'(31);

   logic [3:0]                state_ff, state_in;
   logic [1:0]                ang_ff, ang_in;
   logic [2:0]                pt_ff, pt_in;
   logic [gmg_pkg::CNT_W-1:0] step_ff, step_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ang_in = ang_ff;
      pt_in = pt_ff;
      step_in = step_ff;
      cmd.op = gmg_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op = gmg_pkg::OP_LOAD;
               ang_in = 2'd0;
               state_in = S_RED;
            end
         end
         S_RED: begin
            cmd.op = gmg_pkg::OP_RED;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op = gmg_pkg::OP_MUL;
            state_in = S_ZINIT;
         end
         S_ZINIT: begin
            cmd.op = gmg_pkg::OP_ZINIT;
            step_in = '0;
            state_in = S_ITER;
         end
         S_ITER: begin
            cmd.op = gmg_pkg::OP_ITER;
            if (step_ff == LAST_ITER) state_in = S_SAVE;
            else step_in = step_ff + 1'b1;
         end
         S_SAVE: begin
            cmd.op = gmg_pkg::OP_SAVE;
            if (ang_ff == 2'd3) begin
               pt_in = 3'd0;
               state_in = S_TMUL;
            end else begin
               ang_in = ang_ff + 1'b1;
               state_in = S_RED;
            end
         end
         S_TMUL: begin
            cmd.op = gmg_pkg::OP_TMUL;
            state_in = S_RMUL;
         end
         S_RMUL: begin
            cmd.op = gmg_pkg::OP_RMUL;
            if (pt_ff == 3'd5) begin
               pt_in = 3'd0;
               state_in = S_DABS;
            end else begin
               pt_in = pt_ff + 1'b1;
               state_in = S_TMUL;
            end
         end
         S_DABS: begin
            cmd.op = gmg_pkg::OP_DABS;
            state_in = S_DSQ;
         end
         S_DSQ: begin
            cmd.op = gmg_pkg::OP_DSQ;
            if (pt_ff == 3'd2) begin
               state_in = S_SQINIT;
            end else begin
               pt_in = pt_ff + 1'b1;
               state_in = S_DABS;
            end
         end
         S_SQINIT: begin
            cmd.op = gmg_pkg::OP_SQINIT;
            step_in = '0;
            state_in = S_SQSTEP;
         end
         S_SQSTEP: begin
            cmd.op = gmg_pkg::OP_SQSTEP;
            if (step_ff == LAST_ROOT) state_in = S_FIN;
            else step_in = step_ff + 1'b1;
         end
         S_FIN: begin
            // hold until the result register is free
            if (!status.out_full) begin
               cmd.op = gmg_pkg::OP_FIN;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      cmd.ang = ang_ff;
      cmd.pt = pt_ff;
      cmd.step = step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ang_ff <= '0;
         pt_ff <= '0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         ang_ff <= ang_in;
         pt_ff <= pt_in;
         step_ff <= step_in;
      end
   end

endmodule

@@ sv/gmg_datapath.sv @@
// gmg_datapath: angle reduction, shared CORDIC, coordinate multiplies,
// squared distance, bitwise root and result register. Depends on gmg_pkg.
module gmg_datapath #(
   parameter int CORDIC_STEPS = gmg_pkg::CORDIC_STEPS_DEFAULT,
   parameter int TRIG_FRACTION_BITS = gmg_pkg::TRIG_FRACTION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gmg_pkg::cmd_type                  cmd,
   output gmg_pkg::status_type               status,
   input  logic [63:0]                       req_tdata,
   input  logic                              csr_we,
   input  logic [gmg_pkg::THR_W-1:0]         csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata
);

   localparam int F = TRIG_FRACTION_BITS;
   localparam int XW = F + 3;
   localparam int IW = $clog2(CORDIC_STEPS);
   localparam logic signed [XW-1:0] INV_GAIN = XW'(gmg_pkg::inv_gain(CORDIC_STEPS, F));

   logic [63:0] atan_w [CORDIC_STEPS];
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
      localparam logic [63:0] ATAN_I = gmg_pkg::atan_entry(g);
      assign atan_w[g] = ATAN_I;
   end

   logic [gmg_pkg::LAT_W-1:0]   fix_lat_ff, st_lat_ff;
   logic [gmg_pkg::LON_W-1:0]   fix_lon_ff, st_lon_ff;
   logic [gmg_pkg::THR_W-1:0]   thr_ff;
   logic signed [gmg_pkg::RED_W-1:0] red_ff;
   logic                        neg_ff;
   logic signed [47:0]          phi_ff, plo_ff;
   logic signed [63:0]          z_ff;
   logic signed [XW-1:0]        x_ff, y_ff;
   logic signed [XW-1:0]        sn_ff [4];
   logic signed [XW-1:0]        cs_ff [4];
   logic signed [XW-1:0]        t_ff;
   logic signed [gmg_pkg::COORD_W-1:0] coord_ff [6];
   logic [gmg_pkg::DABS_W-1:0]  dabs_ff;
   logic [63:0]                 sum_ff, v_ff, res_ff, bit_ff;
   logic                        rsp_valid_ff;
   logic [31:0]                 rsp_data_ff;

   // angle select and reduction
   logic signed [gmg_pkg::ANG_W-1:0] ang_sel, ang_wrap, ang_red;
   logic                             red_neg;
   always_comb begin
      case (cmd.ang)
         2'd0:    ang_sel = gmg_pkg::ANG_W'($signed(fix_lat_ff));
         2'd1:    ang_sel = gmg_pkg::ANG_W'($signed(fix_lon_ff));
         2'd2:    ang_sel = gmg_pkg::ANG_W'($signed(st_lat_ff));
         default: ang_sel = gmg_pkg::ANG_W'($signed(st_lon_ff));
      endcase
      if (ang_sel > gmg_pkg::HALF_TURN) ang_wrap = ang_sel - gmg_pkg::FULL_TURN;
      else if (ang_sel < -gmg_pkg::HALF_TURN) ang_wrap = ang_sel + gmg_pkg::FULL_TURN;
      else ang_wrap = ang_sel;
      red_neg = 1'b0;
      ang_red = ang_wrap;
      if (ang_wrap > gmg_pkg::QUARTER_TURN) begin
         ang_red = ang_wrap - gmg_pkg::HALF_TURN;
         red_neg = 1'b1;
      end else if (ang_wrap < -gmg_pkg::QUARTER_TURN) begin
         ang_red = ang_wrap + gmg_pkg::HALF_TURN;
         red_neg = 1'b1;
      end
   end

   // CORDIC step
   logic [IW-1:0]        it;
   logic signed [XW-1:0] dx, dy;
   assign it = cmd.step[IW-1:0];
   assign dx = y_ff >>> it;
   assign dy = x_ff >>> it;

   // trig products for coordinates
   logic signed [XW-1:0] m_a, m_b;
   logic signed [2*XW-1:0] m_p;
   logic                   m_pass;
   always_comb begin
      m_pass = 1'b0;
      case (cmd.pt)
         3'd0: begin m_a = cs_ff[0]; m_b = cs_ff[1]; end
         3'd1: begin m_a = cs_ff[0]; m_b = sn_ff[1]; end
         3'd3: begin m_a = cs_ff[2]; m_b = cs_ff[3]; end
         3'd4: begin m_a = cs_ff[2]; m_b = sn_ff[3]; end
         3'd2: begin m_a = sn_ff[0]; m_b = '0; m_pass = 1'b1; end
         default: begin m_a = sn_ff[2]; m_b = '0; m_pass = 1'b1; end
      endcase
   end
   assign m_p = m_a * m_b;

   logic signed [XW+24:0] r_p;
   assign r_p = t_ff * gmg_pkg::EARTH_RADIUS_M;

   logic [2:0] pt_far;
   logic signed [gmg_pkg::COORD_W:0] diff;
   assign pt_far = cmd.pt + 3'd3;
   assign diff = (gmg_pkg::COORD_W+1)'(coord_ff[cmd.pt])
               - (gmg_pkg::COORD_W+1)'(coord_ff[pt_far]);

   logic [2*gmg_pkg::DABS_W-1:0] sq;
   assign sq = dabs_ff * dabs_ff;

   logic [64:0] rb;
   assign rb = {1'b0, res_ff} + {1'b0, bit_ff};

   logic [gmg_pkg::DIST_W-1:0] dist_m;
   logic                       moved;
   assign dist_m = (|res_ff[63:32]) ? '1 : res_ff[31:8];
   assign moved = (dist_m >= thr_ff);

   always_ff @(posedge clock) begin
      case (cmd.op)
         gmg_pkg::OP_LOAD: begin
            fix_lat_ff <= req_tdata[gmg_pkg::LAT_W-1:0];
            fix_lon_ff <= req_tdata[gmg_pkg::LAT_W +: gmg_pkg::LON_W];
            sum_ff <= '0;
         end
         gmg_pkg::OP_RED: begin
            red_ff <= gmg_pkg::RED_W'(ang_red);
            neg_ff <= red_neg;
         end
         gmg_pkg::OP_MUL: begin
            phi_ff <= 48'(red_ff * $signed({1'b0, gmg_pkg::ANGLE_K_HI}));
            plo_ff <= 48'(red_ff * $signed({1'b0, gmg_pkg::ANGLE_K_LO}));
         end
         gmg_pkg::OP_ZINIT: begin
            z_ff <= (64'(phi_ff) <<< 18) + 64'(plo_ff);
            x_ff <= INV_GAIN;
            y_ff <= '0;
         end
         gmg_pkg::OP_ITER: begin
            if (!z_ff[63]) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - $signed(atan_w[it]);
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + $signed(atan_w[it]);
            end
         end
         gmg_pkg::OP_SAVE: begin
            sn_ff[cmd.ang] <= neg_ff ? -y_ff : y_ff;
            cs_ff[cmd.ang] <= neg_ff ? -x_ff : x_ff;
         end
         gmg_pkg::OP_TMUL: begin
            t_ff <= m_pass ? m_a : XW'(m_p >>> F);
         end
         gmg_pkg::OP_RMUL: begin
            coord_ff[cmd.pt] <= gmg_pkg::COORD_W'(r_p >>> (F - gmg_pkg::COORD_FRAC));
         end
         gmg_pkg::OP_DABS: begin
            dabs_ff <= gmg_pkg::DABS_W'(diff[gmg_pkg::COORD_W] ? -diff : diff);
         end
         gmg_pkg::OP_DSQ: begin
            sum_ff <= sum_ff + 64'(sq);
         end
         gmg_pkg::OP_SQINIT: begin
            v_ff <= sum_ff;
            res_ff <= '0;
            bit_ff <= 64'd1 << 62;
         end
         gmg_pkg::OP_SQSTEP: begin
            if ({1'b0, v_ff} >= rb) begin
               v_ff <= v_ff - rb[63:0];
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         gmg_pkg::OP_FIN: begin
            rsp_data_ff <= {7'd0, moved, dist_m};
         end
         default: ;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_lat_ff <= '0;
         st_lon_ff <= '0;
         thr_ff <= gmg_pkg::THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) thr_ff <= csr_wdata;
         if (cmd.op == gmg_pkg::OP_FIN) begin
            rsp_valid_ff <= 1'b1;
            if (moved) begin
               st_lat_ff <= fix_lat_ff;
               st_lon_ff <= fix_lon_ff;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_full = rsp_valid_ff & ~rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

@@ sv/gps_movement_gate.sv @@
// Each fix runs through the one shared CORDIC unit four times and the
//   32-step bitwise root before its result. A new fix is taken only
//   when the sequencer is idle, after the previous result has been
//   issued; an untaken result holds the sequencer before its next result.
// Reset (synchronous, active high): stored point 0,0, threshold 50 m,
//   no result pending.
module gps_movement_gate #(
   parameter int CORDIC_STEPS = gmg_pkg::CORDIC_STEPS_DEFAULT,
   parameter int TRIG_FRACTION_BITS = gmg_pkg::TRIG_FRACTION_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // fix input: [27:0] fix_latitude, [56:28] fix_longitude, [63:57] zero
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [63:0]               req_tdata,
   // result: [23:0] distance_m, [24] moved, [31:25] zero
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,
   // threshold register, meters
   input  logic                      csr_we,
   input  logic [gmg_pkg::THR_W-1:0] csr_wdata
);

   gmg_pkg::cmd_type    cmd;
   gmg_pkg::status_type status;

   // sequencer: one command per cycle unless stalled, counts CORDIC and root steps
   gmg_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: reduction, CORDIC, coordinates, distance, root, result
   gmg_datapath #(
      .CORDIC_STEPS       (CORDIC_STEPS),
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
